// ----- rtl/bsa_pkg.sv -----
package bsa_pkg;

    localparam int NUM_PAGES   = 16;
    localparam int PAGE_BYTES  = 4096;
    localparam int NUM_CLASSES = 9;
    localparam int MIN_SHIFT   = 4;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int BLOCKS_MAX  = PAGE_BYTES / 16;
    localparam int PAGE_W      = $clog2(NUM_PAGES);
    localparam int PTR_W       = PAGE_W + 1;
    localparam int BLK_W       = $clog2(BLOCKS_MAX);
    localparam int CNT_W       = BLK_W + 1;
    localparam int CLS_W       = 4;
    localparam int MEM_AW      = PAGE_W + BLK_W;
    localparam int ADDR_W      = 16;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_PAGE   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic    load;
        logic    a_cls;
        logic    a_walk;
        logic    a_claim;
        logic    a_take;
        logic    a_pop;
        logic    f_cls_init;
        logic    f_cls_next;
        logic    f_cls_open;
        logic    f_walk;
        logic    f_upd;
        logic    err;
        status_t err_code;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic size_big;
        logic cur_null;
        logic steps_max;
        logic has_free;
        logic no_free;
        logic top_nz;
        logic page_bad;
        logic cls_end;
        logic cls_skip;
        logic cur_match;
    } sts_t;

    // Block size of a class, wide enough to hold PAGE_BYTES.
    function automatic logic [PAGE_SHIFT:0] class_bytes(input logic [CLS_W-1:0] c);
        class_bytes = (PAGE_SHIFT+1)'(1 << MIN_SHIFT) << c;
    endfunction

    function automatic logic [CNT_W-1:0] class_blocks(input logic [CLS_W-1:0] c);
        class_blocks = CNT_W'(BLOCKS_MAX) >> c;
    endfunction

endpackage

// ----- rtl/bucket_slab_allocator.sv -----
// An allocate picks the class, walks the class's page list a page at a time, claims a new
// page if none had room, and takes a block, popping the free list if it is not empty.
// A free checks the page, skips the classes below the hint and walks the pages of each
// class searched, then updates the page. One word is in flight at a time; busy stays high
// until done ends, so the next word can be taken in the cycle after done.
// Reset clears page ownership and list heads at once; results show for one cycle, no stall.
module bucket_slab_allocator
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       op,
    input  logic [15:0]                request_size,
    input  logic [15:0]                block_address,
    input  logic [15:0]                size_hint,
    output logic                       done,
    output logic [15:0]                alloc_address,
    output logic [1:0]                 status
);
    import bsa_pkg::*;

    // The controller sequences the list walks; the datapath holds every record.
    cmd_t    cmd;
    sts_t    sts;
    status_t status_w;

    bsa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bsa_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (op),
        .request_size  (request_size),
        .block_address (block_address),
        .size_hint     (size_hint),
        .sts           (sts),
        .alloc_address (alloc_address),
        .status        (status_w)
    );

    assign status = 2'(status_w);

endmodule

// ----- rtl/bsa_ctrl.sv -----
module bsa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bsa_pkg::sts_t sts,
    output bsa_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done
);
    import bsa_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_ACLS   = 11'b000_0000_0010,
        S_AWALK  = 11'b000_0000_0100,
        S_ACLAIM = 11'b000_0000_1000,
        S_ATAKE  = 11'b000_0001_0000,
        S_APOP   = 11'b000_0010_0000,
        S_FCHK   = 11'b000_0100_0000,
        S_FCLS   = 11'b000_1000_0000,
        S_FWALK  = 11'b001_0000_0000,
        S_FUPD   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.op ? S_FCHK : S_ACLS;
                end
            end
            S_ACLS:
            begin
                if (sts.size_big)
                begin
                    cmd.err      = 1'b1;
                    cmd.err_code = ST_TOO_LARGE;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.a_cls  = 1'b1;
                    state_next = S_AWALK;
                end
            end
            S_AWALK:
            begin
                if (sts.cur_null || sts.steps_max)
                begin
                    state_next = S_ACLAIM;
                end
                else
                begin
                    cmd.a_walk = 1'b1;
                    if (sts.has_free)
                    begin
                        state_next = S_ATAKE;
                    end
                end
            end
            S_ACLAIM:
            begin
                if (sts.no_free)
                begin
                    cmd.err      = 1'b1;
                    cmd.err_code = ST_NO_PAGE;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.a_claim = 1'b1;
                    state_next  = S_ATAKE;
                end
            end
            S_ATAKE:
            begin
                cmd.a_take = 1'b1;
                state_next = sts.top_nz ? S_APOP : S_DONE;
            end
            S_APOP:
            begin
                cmd.a_pop  = 1'b1;
                state_next = S_DONE;
            end
            S_FCHK:
            begin
                if (sts.page_bad)
                begin
                    cmd.err      = 1'b1;
                    cmd.err_code = ST_NOT_FOUND;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.f_cls_init = 1'b1;
                    state_next     = S_FCLS;
                end
            end
            S_FCLS:
            begin
                if (sts.cls_end)
                begin
                    cmd.err      = 1'b1;
                    cmd.err_code = ST_NOT_FOUND;
                    state_next   = S_DONE;
                end
                else if (sts.cls_skip)
                begin
                    cmd.f_cls_next = 1'b1;
                end
                else
                begin
                    cmd.f_cls_open = 1'b1;
                    state_next     = S_FWALK;
                end
            end
            S_FWALK:
            begin
                if (sts.cur_match)
                begin
                    state_next = S_FUPD;
                end
                else if (sts.cur_null || sts.steps_max)
                begin
                    cmd.f_cls_next = 1'b1;
                    state_next     = S_FCLS;
                end
                else
                begin
                    cmd.f_walk = 1'b1;
                end
            end
            S_FUPD:
            begin
                cmd.f_upd  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bsa_dp.sv -----
module bsa_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsa_pkg::cmd_t                cmd,
    input  logic                         op,
    input  logic [15:0]                  request_size,
    input  logic [15:0]                  block_address,
    input  logic [15:0]                  size_hint,
    output bsa_pkg::sts_t                sts,
    output logic [bsa_pkg::ADDR_W-1:0]   alloc_address,
    output bsa_pkg::status_t             status
);
    import bsa_pkg::*;

    // Allocator state.
    logic [NUM_PAGES-1:0] in_use_reg;
    logic [PTR_W-1:0]     head_reg [NUM_CLASSES];
    logic [PTR_W-1:0]     next_reg [NUM_PAGES];
    logic [CNT_W-1:0]     top_reg  [NUM_PAGES];
    logic [CNT_W-1:0]     bump_reg [NUM_PAGES];
    logic [CNT_W-1:0]     ref_reg  [NUM_PAGES];
    logic [CNT_W-1:0]     link_mem [BLOCKS_MAX*NUM_PAGES];
    logic [CNT_W-1:0]     link_q_reg;

    // Working registers of the current word.
    logic [15:0]          size_reg;
    logic [15:0]          addr_reg;
    logic [15:0]          hint_reg;
    logic [CLS_W-1:0]     cls_reg;
    logic [PTR_W-1:0]     cur_reg;
    logic [PTR_W-1:0]     prev_reg;
    logic [PTR_W-1:0]     steps_reg;
    logic [PAGE_W-1:0]    pg_reg;
    logic [BLK_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]    res_addr_reg;
    status_t              res_status_reg;

    logic [PAGE_W-1:0]    rd_pg;
    logic [CLS_W-1:0]     size_cls;
    logic                 size_big;
    logic [PAGE_W-1:0]    free_pg;
    logic                 no_free;
    logic [PAGE_W-1:0]    addr_pg;
    logic [BLK_W-1:0]     free_idx;
    logic [CNT_W-1:0]     ref_dec;
    logic [BLK_W-1:0]     pop_idx;
    logic [BLK_W-1:0]     bump_idx;

    assign rd_pg    = (cmd.a_walk || cmd.f_walk || cmd.a_take == 1'b0 && cmd.a_pop == 1'b0
                       && cmd.f_upd == 1'b0 && cmd.a_claim == 1'b0) ?
                      PAGE_W'(cur_reg - PTR_W'(1)) : pg_reg;
    assign addr_pg  = addr_reg[PAGE_SHIFT +: PAGE_W];
    assign free_idx = BLK_W'(addr_reg[PAGE_SHIFT-1:0] >> (cls_reg + CLS_W'(MIN_SHIFT)));
    assign ref_dec  = (ref_reg[pg_reg] != '0) ? ref_reg[pg_reg] - CNT_W'(1) : '0;
    assign pop_idx  = BLK_W'(top_reg[pg_reg] - CNT_W'(1));
    assign bump_idx = BLK_W'(bump_reg[pg_reg]);

    // Smallest class that fits the request.
    always_comb
    begin
        size_cls = '0;
        size_big = 1'b1;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if ({1'b0, size_reg} <= 17'(class_bytes(CLS_W'(c))))
            begin
                size_cls = CLS_W'(c);
                size_big = 1'b0;
            end
        end
    end

    // Lowest-numbered page not in use.
    always_comb
    begin
        free_pg = '0;
        no_free = 1'b1;
        for (int p = NUM_PAGES - 1; p >= 0; p--)
        begin
            if (!in_use_reg[p])
            begin
                free_pg = PAGE_W'(p);
                no_free = 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.op        = op;
        sts.size_big  = size_big;
        sts.cur_null  = (cur_reg == '0);
        sts.steps_max = (steps_reg == PTR_W'(NUM_PAGES));
        sts.has_free  = (top_reg[rd_pg] != '0) || (bump_reg[rd_pg] < class_blocks(cls_reg));
        sts.no_free   = no_free;
        sts.top_nz    = (top_reg[pg_reg] != '0);
        sts.page_bad  = ((PTR_W+1)'(addr_reg >> PAGE_SHIFT) >= (PTR_W+1)'(NUM_PAGES));
        sts.cls_end   = (cls_reg == CLS_W'(NUM_CLASSES));
        sts.cls_skip  = ({5'b0, class_bytes(cls_reg)} < {2'b0, hint_reg});
        sts.cur_match = (cur_reg == PTR_W'(addr_pg) + PTR_W'(1));
    end

    // Control state: page ownership and list heads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= '0;
            end
        end
        else
        begin
            if (cmd.a_claim)
            begin
                in_use_reg[free_pg] <= 1'b1;
                head_reg[cls_reg]   <= PTR_W'(free_pg) + PTR_W'(1);
            end
            if (cmd.f_upd && ref_dec == '0)
            begin
                in_use_reg[pg_reg] <= 1'b0;
                if (prev_reg == '0)
                begin
                    head_reg[cls_reg] <= next_reg[pg_reg];
                end
            end
        end
    end

    // Per-page records and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            size_reg <= request_size;
            addr_reg <= block_address;
            hint_reg <= size_hint;
        end
        if (cmd.a_cls)
        begin
            cls_reg   <= size_cls;
            cur_reg   <= head_reg[size_cls];
            steps_reg <= '0;
        end
        if (cmd.a_walk)
        begin
            pg_reg    <= rd_pg;
            cur_reg   <= next_reg[rd_pg];
            steps_reg <= steps_reg + PTR_W'(1);
        end
        if (cmd.a_claim)
        begin
            pg_reg            <= free_pg;
            top_reg[free_pg]  <= '0;
            bump_reg[free_pg] <= '0;
            ref_reg[free_pg]  <= '0;
            next_reg[free_pg] <= head_reg[cls_reg];
        end
        if (cmd.a_take)
        begin
            if (top_reg[pg_reg] != '0)
            begin
                idx_reg <= pop_idx;
            end
            else
            begin
                bump_reg[pg_reg] <= bump_reg[pg_reg] + CNT_W'(1);
                ref_reg[pg_reg]  <= ref_reg[pg_reg] + CNT_W'(1);
                res_addr_reg     <= {pg_reg, PAGE_SHIFT'({4'b0, bump_idx}
                                     << (cls_reg + CLS_W'(MIN_SHIFT)))};
                res_status_reg   <= ST_OK;
            end
        end
        if (cmd.a_pop)
        begin
            top_reg[pg_reg] <= link_q_reg;
            ref_reg[pg_reg] <= ref_reg[pg_reg] + CNT_W'(1);
            res_addr_reg    <= {pg_reg, PAGE_SHIFT'({4'b0, idx_reg}
                                << (cls_reg + CLS_W'(MIN_SHIFT)))};
            res_status_reg  <= ST_OK;
        end
        if (cmd.f_cls_init)
        begin
            cls_reg <= '0;
            pg_reg  <= addr_pg;
        end
        if (cmd.f_cls_next)
        begin
            cls_reg <= cls_reg + CLS_W'(1);
        end
        if (cmd.f_cls_open)
        begin
            cur_reg   <= head_reg[cls_reg];
            prev_reg  <= '0;
            steps_reg <= '0;
        end
        if (cmd.f_walk)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= next_reg[rd_pg];
            steps_reg <= steps_reg + PTR_W'(1);
        end
        if (cmd.f_upd)
        begin
            top_reg[pg_reg] <= CNT_W'(free_idx) + CNT_W'(1);
            ref_reg[pg_reg] <= ref_dec;
            if (ref_dec == '0 && prev_reg != '0)
            begin
                next_reg[PAGE_W'(prev_reg - PTR_W'(1))] <= next_reg[pg_reg];
            end
            res_addr_reg   <= '0;
            res_status_reg <= ST_OK;
        end
        if (cmd.err)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= cmd.err_code;
        end
    end

    // Free-block links, one word per block of every page.
    always_ff @(posedge clk)
    begin
        if (cmd.f_upd)
        begin
            link_mem[{pg_reg, free_idx}] <= top_reg[pg_reg];
        end
        link_q_reg <= link_mem[{pg_reg, pop_idx}];
    end

    assign alloc_address = res_addr_reg;
    assign status        = res_status_reg;

endmodule
